>>> design/max_independent_set_search_defines.svh
// assertion macros for the independent set search block
`ifndef MAX_INDEPENDENT_SET_SEARCH_DEFINES_SVH
`define MAX_INDEPENDENT_SET_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk and disabled during reset
`define MIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and disabled during reset
`define MIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mis_pkg.sv
// shared types and constants for the independent set search block
`timescale 1ns / 1ps

package mis_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int VERT_W           = 6;
  localparam int SIZE_W           = 6;
  localparam int MASK_W           = 32;
  localparam logic [VERT_W-1:0] VCOUNT_RESET = 6'd32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT0,
    S_CNT1,
    S_CHECK,
    S_RET,
    S_RESTORE,
    S_DONE
  } srch_state_t;

  typedef struct packed {
    logic              en;
    logic [VERT_W-1:0] u;
    logic [VERT_W-1:0] v;
  } adj_wr_t;

endpackage

>>> design/mis_adj.sv
// adjacency matrix: symmetric edge insert, one row read, synchronous clear
`timescale 1ns / 1ps

module mis_adj #(
  parameter int MAX_VERTICES = mis_pkg::MAX_VERTICES_DEF,
  parameter int VW           = $clog2(MAX_VERTICES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mis_pkg::adj_wr_t        wr_i,
  input  logic                    clr_i,
  input  logic [VW-1:0]           rd_idx_i,
  output logic [MAX_VERTICES-1:0] rd_row_o
);
  import mis_pkg::*;

  logic [MAX_VERTICES-1:0] adj_r [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (!rst_n || clr_i) begin
      adj_r <= '{default: '0};
    end else if (wr_i.en) begin
      adj_r[wr_i.u[VW-1:0]][wr_i.v[VW-1:0]] <= 1'b1;
      adj_r[wr_i.v[VW-1:0]][wr_i.u[VW-1:0]] <= 1'b1;
    end
  end

  assign rd_row_o = adj_r[rd_idx_i];

endmodule

>>> design/mis_popcnt.sv
// two-stage population count: per-byte counts, then their sum
`timescale 1ns / 1ps

module mis_popcnt #(
  parameter int W  = mis_pkg::MAX_VERTICES_DEF,
  parameter int CW = $clog2(W + 1)
) (
  input  logic          clk,
  input  logic [W-1:0]  vec_i,
  output logic [CW-1:0] cnt_o
);
  import mis_pkg::*;

  localparam int NB = (W + 7) / 8;
  localparam int PW = NB * 8;

  logic [PW-1:0] pad;
  logic [3:0]    byte_cnt     [NB];
  logic [3:0]    byte_cnt_r   [NB];
  logic [CW-1:0] sum_nxt;
  logic [CW-1:0] cnt_r;

  assign pad = PW'(vec_i);

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(pad[b*8+k]);
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int b = 0; b < NB; b++) begin
      sum_nxt = sum_nxt + CW'(byte_cnt_r[b]);
    end
  end

  always_ff @(posedge clk) begin
    byte_cnt_r <= byte_cnt;
    cnt_r      <= sum_nxt;
  end

  assign cnt_o = cnt_r;

endmodule

>>> design/mis_stack.sv
// search frame memory: one write and one registered read per cycle
`timescale 1ns / 1ps

module mis_stack #(
  parameter int DEPTH = mis_pkg::MAX_VERTICES_DEF,
  parameter int DW    = 38,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  import mis_pkg::*;

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    rdata_r <= mem_r[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

>>> design/mis_search.sv
// depth-first branch and bound sequencer around the shared bit counter
`timescale 1ns / 1ps
`include "max_independent_set_search_defines.svh"

module mis_search #(
  parameter int MAX_VERTICES = mis_pkg::MAX_VERTICES_DEF,
  parameter int VW           = $clog2(MAX_VERTICES),
  parameter int IW           = $clog2(MAX_VERTICES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start_i,
  input  logic [IW-1:0]           n_i,
  input  logic [MAX_VERTICES-1:0] adj_row_i,
  output logic [VW-1:0]           adj_idx_o,
  output logic                    adj_clr_o,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [MAX_VERTICES-1:0] best_set_o,
  output logic [IW-1:0]           best_cnt_o
);
  import mis_pkg::*;

  localparam int CW = IW;
  localparam int SW = CW + MAX_VERTICES;

  srch_state_t state_r, state_nxt;

  logic [IW-1:0]           idx_r;
  logic [CW-1:0]           count_r;
  logic [MAX_VERTICES-1:0] cand_r;
  logic [MAX_VERTICES-1:0] cur_r;
  logic [MAX_VERTICES-1:0] excl_r;
  logic [MAX_VERTICES-1:0] best_set_r;
  logic [CW-1:0]           best_cnt_r;
  logic [IW-1:0]           n_r;

  logic [CW-1:0]           pc;
  logic [MAX_VERTICES-1:0] low_mask;
  logic [MAX_VERTICES-1:0] bit_sel;
  logic [MAX_VERTICES-1:0] p_bit;
  logic [IW-1:0]           p_idx;
  logic [CW:0]             bound_sum;
  logic                    prune;
  logic                    leaf;
  logic                    incl_ok;
  logic                    st_we;
  logic [SW-1:0]           st_rdata;
  logic [CW-1:0]           st_count;
  logic [MAX_VERTICES-1:0] st_cand;

  mis_popcnt #(
    .W  (MAX_VERTICES),
    .CW (CW)
  ) u_popcnt (
    .clk   (clk),
    .vec_i (cand_r),
    .cnt_o (pc)
  );

  mis_stack #(
    .DEPTH (MAX_VERTICES),
    .DW    (SW),
    .AW    (VW)
  ) u_stack (
    .clk     (clk),
    .we_i    (st_we),
    .waddr_i (idx_r[VW-1:0]),
    .wdata_i ({count_r, cand_r}),
    .raddr_i (p_idx[VW-1:0]),
    .rdata_o (st_rdata)
  );

  assign st_count = st_rdata[SW-1:MAX_VERTICES];
  assign st_cand  = st_rdata[MAX_VERTICES-1:0];

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      low_mask[i] = (IW'(i) < n_i);
    end
  end

  assign bit_sel   = MAX_VERTICES'(1) << idx_r[VW-1:0];
  assign p_idx     = idx_r - IW'(1);
  assign p_bit     = MAX_VERTICES'(1) << p_idx[VW-1:0];
  assign bound_sum = (CW+1)'(count_r) + (CW+1)'(pc);
  // a subtree that cannot beat the best strictly is skipped
  assign prune     = bound_sum <= (CW+1)'(best_cnt_r);
  assign leaf      = idx_r >= n_r;
  assign incl_ok   = |(cand_r & bit_sel);
  assign st_we     = (state_r == S_CHECK) && !prune && !leaf && incl_ok;
  assign adj_idx_o = idx_r[VW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (start_i) state_nxt = S_CNT0;
      S_CNT0:    state_nxt = S_CNT1;
      S_CNT1:    state_nxt = S_CHECK;
      S_CHECK:   state_nxt = (prune || leaf) ? S_RET : S_CNT0;
      S_RET: begin
        priority if (idx_r == '0) state_nxt = S_DONE;
        else if (excl_r[p_idx[VW-1:0]]) state_nxt = S_RET;
        else state_nxt = S_RESTORE;
      end
      S_RESTORE: state_nxt = S_CNT0;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o    = (state_r != S_IDLE);
    done_o    = (state_r == S_DONE);
    adj_clr_o = (state_r == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      cur_r  <= '0;
      excl_r <= '0;
      n_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start_i) begin
            idx_r      <= '0;
            count_r    <= '0;
            cand_r     <= low_mask;
            cur_r      <= '0;
            excl_r     <= '0;
            best_set_r <= '0;
            best_cnt_r <= '0;
            n_r        <= n_i;
          end
        end
        S_CHECK: begin
          if (!prune) begin
            if (leaf) begin
              best_cnt_r <= count_r;
              best_set_r <= cur_r;
            end else if (incl_ok) begin
              // include branch first, frame saved for the exclude pass
              cur_r   <= cur_r | bit_sel;
              excl_r  <= excl_r & ~bit_sel;
              cand_r  <= cand_r & ~bit_sel & ~adj_row_i;
              count_r <= count_r + CW'(1);
              idx_r   <= idx_r + IW'(1);
            end else begin
              excl_r <= excl_r | bit_sel;
              cand_r <= cand_r & ~bit_sel;
              idx_r  <= idx_r + IW'(1);
            end
          end
        end
        S_RET: begin
          if (idx_r != '0) begin
            idx_r <= p_idx;
            if (excl_r[p_idx[VW-1:0]]) begin
              excl_r <= excl_r & ~p_bit;
            end
          end
        end
        S_RESTORE: begin
          // parent frame now takes its exclude branch
          cur_r   <= cur_r & ~bit_sel;
          excl_r  <= excl_r | bit_sel;
          cand_r  <= st_cand & ~bit_sel;
          count_r <= st_count;
          idx_r   <= idx_r + IW'(1);
        end
        S_CNT0, S_CNT1, S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign best_set_o = best_set_r;
  assign best_cnt_o = best_cnt_r;

  `MIS_ASSERT_NOW(a_start_idle, start_i, state_r == S_IDLE, "search started while busy")
  `MIS_ASSERT_NOW(a_path_disjoint, 1'b1, (cur_r & excl_r) == '0, "vertex both in and out")
  `MIS_ASSERT_NOW(a_idx_range, state_r != S_IDLE, idx_r <= n_r, "depth beyond vertex count")
  `MIS_ASSERT_NOW(a_best_count, state_r == S_DONE, $countones(best_set_r) == int'(best_cnt_r), "best count mismatch")
  `MIS_ASSERT_NEXT(a_done_pulse, state_r == S_DONE, state_r == S_IDLE, "result strobe too long")

endmodule

>>> design/max_independent_set_search.sv
// top level: edge loading, vertex count register and maximum independent set search
// a last beat starts the search: each node checked passes S_CNT0, S_CNT1 and S_CHECK while
// the registered counter settles; each backtrack step and exclude restore has its own state
// throughput: one edge beat per cycle; busy holds off input for the whole search, result
// strobe out_valid is high one cycle and cannot be stalled; sync active-low reset, count 32
`timescale 1ns / 1ps

module max_independent_set_search #(
  parameter int MAX_VERTICES = mis_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mis_pkg::VERT_W-1:0]  in_vertex_u,
  input  logic [mis_pkg::VERT_W-1:0]  in_vertex_v,
  input  logic                        in_edge_present,
  input  logic                        in_last_item,
  output logic                        out_valid,
  output logic [mis_pkg::SIZE_W-1:0]  out_set_size,
  output logic [mis_pkg::MASK_W-1:0]  out_member_mask,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mis_pkg::VERT_W-1:0]  cfg_vertex_count
);
  import mis_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int IW = $clog2(MAX_VERTICES + 1);

  logic [VERT_W-1:0]       vcount_r;
  logic [6:0]              vc_ext;
  logic [6:0]              n_ext;
  logic                    accept;
  adj_wr_t                 adj_wr;
  logic                    adj_clr;
  logic [VW-1:0]           adj_idx;
  logic [MAX_VERTICES-1:0] adj_row;
  logic                    srch_busy;
  logic                    srch_done;
  logic [MAX_VERTICES-1:0] best_set;
  logic [IW-1:0]           best_cnt;
  logic [6:0]              cnt_ext;
  logic [63:0]             set_ext;

  assign cfg_ready = !srch_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vcount_r <= cfg_vertex_count;
    end
  end

  assign vc_ext = 7'(vcount_r);
  assign n_ext  = (vc_ext > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vc_ext;
  assign accept = start && !srch_busy;

  // self-loops and endpoints past the active count are dropped
  always_comb begin
    adj_wr.en = accept && in_edge_present && (in_vertex_u != in_vertex_v)
                && (7'(in_vertex_u) < n_ext) && (7'(in_vertex_v) < n_ext);
    adj_wr.u  = in_vertex_u;
    adj_wr.v  = in_vertex_v;
  end

  mis_adj #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW)
  ) u_adj (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_i     (adj_wr),
    .clr_i    (adj_clr),
    .rd_idx_i (adj_idx),
    .rd_row_o (adj_row)
  );

  mis_search #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW),
    .IW           (IW)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (accept && in_last_item),
    .n_i        (IW'(n_ext)),
    .adj_row_i  (adj_row),
    .adj_idx_o  (adj_idx),
    .adj_clr_o  (adj_clr),
    .busy_o     (srch_busy),
    .done_o     (srch_done),
    .best_set_o (best_set),
    .best_cnt_o (best_cnt)
  );

  assign busy      = srch_busy;
  assign out_valid = srch_done;

  assign cnt_ext         = 7'(best_cnt);
  assign out_set_size    = (cnt_ext > 7'd63) ? 6'd63 : cnt_ext[5:0];
  assign set_ext         = 64'(best_set);
  assign out_member_mask = set_ext[MASK_W-1:0];

endmodule
